### design/pmd_pkg.sv
// ----------------------------------------------------------------------------
// pmd_pkg
// Types and constants shared by the payload message deframer modules.
// ----------------------------------------------------------------------------
package pmd_pkg;

  localparam int TABLE_SIZE = 22;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);

  localparam logic [2:0] CAUSE_RAN_TO_END = 3'd0;
  localparam logic [2:0] CAUSE_SHORT_HDR  = 3'd1;
  localparam logic [2:0] CAUSE_ZERO_LEN   = 3'd2;
  localparam logic [2:0] CAUSE_TRUNCATED  = 3'd3;
  localparam logic [2:0] CAUSE_LIMIT      = 3'd4;

  localparam logic [7:0] TYPE_TABLE [TABLE_SIZE] = '{
    8'h97, 8'h3B, 8'h37, 8'h38, 8'h58, 8'h39, 8'h3A, 8'h3C, 8'h3D, 8'h3E, 8'hE3,
    8'h2D, 8'h59, 8'h5A, 8'h01, 8'h02, 8'h03, 8'h04, 8'h80, 8'h81, 8'h82, 8'h83
  };

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       payload_end;
  } in_item_t;

  typedef struct packed {
    logic        is_summary;
    logic [7:0]  type_code;
    logic [7:0]  message_length;
    logic        type_known;
    logic [4:0]  type_slot;
    logic [15:0] message_ordinal;
    logic [2:0]  stop_cause;
  } out_item_t;

  // one queue entry: up to one report and one summary from a single byte
  typedef struct packed {
    logic        has_report;
    logic        has_summary;
    logic [7:0]  type_byte;
    logic [7:0]  len_byte;
    logic [15:0] ordinal;
    logic [2:0]  cause;
  } work_t;

endpackage

### design/pmd_front.sv
// ----------------------------------------------------------------------------
// pmd_front
// Byte parser: header skip, length/type/body tracking, stop handling.
// ----------------------------------------------------------------------------
module pmd_front #(
  parameter int HEADER_BYTES = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             accept,
  input  pmd_pkg::in_item_t item,
  input  logic             cfg_we,
  input  logic [7:0]       cfg_limit,
  output logic             push,
  output pmd_pkg::work_t   push_entry
);

  localparam int HW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES + 1) : 1;

  typedef enum logic [2:0] {
    PH_HDR, PH_LEN, PH_TYPE, PH_BODY, PH_STOP
  } phase_t;

  localparam phase_t PH_START = (HEADER_BYTES > 0) ? PH_HDR : PH_LEN;

  phase_t      phase_r, phase_nxt;
  logic [HW-1:0] hdr_r, hdr_nxt;
  logic [7:0]  bim_r, bim_nxt;
  logic [7:0]  len_r, len_nxt;
  logic [7:0]  type_r, type_nxt;
  logic [15:0] cnt_r, cnt_nxt;
  logic [2:0]  cause_r, cause_nxt;
  logic [7:0]  limit_r;

  logic [15:0] cnt_inc;
  logic        hit;
  logic        rep;
  logic [7:0]  rep_type;
  logic [7:0]  bim_inc;
  logic [HW:0] hdr_inc;
  logic [2:0]  sum_cause;

  assign cnt_inc = (cnt_r == 16'hFFFF) ? cnt_r : cnt_r + 16'd1;
  assign hit     = (limit_r != 8'd0) && (cnt_inc >= {8'd0, limit_r});
  assign bim_inc = bim_r + 8'd1;
  assign hdr_inc = {1'b0, hdr_r} + (HW+1)'(1);

  always_comb begin
    phase_nxt = phase_r;
    hdr_nxt   = hdr_r;
    bim_nxt   = bim_r;
    len_nxt   = len_r;
    type_nxt  = type_r;
    cnt_nxt   = cnt_r;
    cause_nxt = cause_r;
    rep       = 1'b0;
    rep_type  = type_r;
    sum_cause = pmd_pkg::CAUSE_RAN_TO_END;
    case (phase_r)
      PH_HDR: begin
        hdr_nxt = hdr_inc[HW-1:0];
        if (hdr_inc >= (HW+1)'(HEADER_BYTES)) begin
          phase_nxt = PH_LEN;
        end
      end
      PH_LEN: begin
        len_nxt   = item.payload_byte;
        bim_nxt   = 8'd1;
        phase_nxt = PH_TYPE;
      end
      PH_TYPE: begin
        type_nxt = item.payload_byte;
        rep_type = item.payload_byte;
        bim_nxt  = 8'd2;
        if (len_r == 8'd0) begin
          phase_nxt = PH_STOP;
          cause_nxt = pmd_pkg::CAUSE_ZERO_LEN;
        end else if (len_r == 8'd1) begin
          rep     = 1'b1;
          cnt_nxt = cnt_inc;
          if (hit) begin
            phase_nxt = PH_STOP;
            cause_nxt = pmd_pkg::CAUSE_LIMIT;
          end else begin
            len_nxt   = item.payload_byte;
            bim_nxt   = 8'd1;
            phase_nxt = PH_TYPE;
          end
        end else if (len_r == 8'd2) begin
          rep       = 1'b1;
          cnt_nxt   = cnt_inc;
          phase_nxt = PH_LEN;
          if (!item.payload_end && hit) begin
            phase_nxt = PH_STOP;
            cause_nxt = pmd_pkg::CAUSE_LIMIT;
          end
        end else begin
          phase_nxt = PH_BODY;
        end
      end
      PH_BODY: begin
        bim_nxt = bim_inc;
        if (bim_inc >= len_r) begin
          rep       = 1'b1;
          cnt_nxt   = cnt_inc;
          phase_nxt = PH_LEN;
          if (!item.payload_end && hit) begin
            phase_nxt = PH_STOP;
            cause_nxt = pmd_pkg::CAUSE_LIMIT;
          end
        end
      end
      default: begin
      end
    endcase

    case (phase_nxt)
      PH_STOP: sum_cause = cause_nxt;
      PH_HDR:  sum_cause = pmd_pkg::CAUSE_SHORT_HDR;
      PH_LEN:  sum_cause = pmd_pkg::CAUSE_RAN_TO_END;
      default: sum_cause = pmd_pkg::CAUSE_TRUNCATED;
    endcase
  end

  assign push                   = accept && (rep || item.payload_end);
  assign push_entry.has_report  = rep;
  assign push_entry.has_summary = item.payload_end;
  assign push_entry.type_byte   = rep_type;
  assign push_entry.len_byte    = len_r;
  assign push_entry.ordinal     = cnt_nxt;
  assign push_entry.cause       = sum_cause;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_START;
      hdr_r   <= '0;
      bim_r   <= 8'd0;
      len_r   <= 8'd0;
      type_r  <= 8'd0;
      cnt_r   <= 16'd0;
      cause_r <= pmd_pkg::CAUSE_RAN_TO_END;
      limit_r <= 8'd100;
    end else begin
      if (cfg_we) begin
        limit_r <= cfg_limit;
      end
      if (accept) begin
        if (item.payload_end) begin
          phase_r <= PH_START;
          hdr_r   <= '0;
          bim_r   <= 8'd0;
          len_r   <= 8'd0;
          type_r  <= 8'd0;
          cnt_r   <= 16'd0;
          cause_r <= pmd_pkg::CAUSE_RAN_TO_END;
        end else begin
          phase_r <= phase_nxt;
          hdr_r   <= hdr_nxt;
          bim_r   <= bim_nxt;
          len_r   <= len_nxt;
          type_r  <= type_nxt;
          cnt_r   <= cnt_nxt;
          cause_r <= cause_nxt;
        end
      end
    end
  end

endmodule

### design/pmd_queue.sv
// ----------------------------------------------------------------------------
// pmd_queue
// Short FIFO of parsed work between the parser and the output stage.
// ----------------------------------------------------------------------------
module pmd_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  pmd_pkg::work_t push_entry,
  input  logic           pop,
  output pmd_pkg::work_t head,
  output logic           not_empty,
  output logic           full
);

  pmd_pkg::work_t mem [pmd_pkg::QDEPTH];

  logic [pmd_pkg::QPTR_W-1:0] wr_r, rd_r;
  logic [pmd_pkg::QPTR_W:0]   cnt_r;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (pmd_pkg::QPTR_W+1)'(pmd_pkg::QDEPTH));
  assign head      = mem[rd_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_r] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wr_r <= wr_r + (pmd_pkg::QPTR_W)'(1);
      end
      if (pop) begin
        rd_r <= rd_r + (pmd_pkg::QPTR_W)'(1);
      end
      case ({push, pop})
        2'b10:   cnt_r <= cnt_r + (pmd_pkg::QPTR_W+1)'(1);
        2'b01:   cnt_r <= cnt_r - (pmd_pkg::QPTR_W+1)'(1);
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

### design/pmd_back.sv
// ----------------------------------------------------------------------------
// pmd_back
// Output stage: type table match, report/summary sequencing, output register.
// ----------------------------------------------------------------------------
module pmd_back #(
  parameter int TYPE_TABLE_ENTRIES = 22
) (
  input  logic               clk,
  input  logic               rst_n,
  input  pmd_pkg::work_t     head,
  input  logic               head_valid,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output pmd_pkg::out_item_t out_data
);

  logic               out_valid_r;
  pmd_pkg::out_item_t out_r, out_nxt;
  logic               rep_done_r;
  logic               load;
  logic               emit_rep;
  logic               known;
  logic [4:0]         slot;

  always_comb begin
    known = 1'b0;
    slot  = 5'd0;
    for (int i = pmd_pkg::TABLE_SIZE - 1; i >= 0; i--) begin
      if (i < TYPE_TABLE_ENTRIES && pmd_pkg::TYPE_TABLE[i] == head.type_byte) begin
        known = 1'b1;
        slot  = 5'(i);
      end
    end
  end

  assign load     = head_valid && (!out_valid_r || out_ready);
  assign emit_rep = head.has_report && !rep_done_r;
  assign pop      = load && !(emit_rep && head.has_summary);

  always_comb begin
    out_nxt                 = '0;
    out_nxt.message_ordinal = head.ordinal;
    if (emit_rep) begin
      out_nxt.type_code      = head.type_byte;
      out_nxt.message_length = head.len_byte;
      out_nxt.type_known     = known;
      out_nxt.type_slot      = slot;
    end else begin
      out_nxt.is_summary = 1'b1;
      out_nxt.stop_cause = head.cause;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_r <= out_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      rep_done_r  <= 1'b0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        rep_done_r  <= !pop;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

### design/payload_message_deframer.sv
// ----------------------------------------------------------------------------
// payload_message_deframer
// Splits a byte-wide packet payload into length-prefixed messages.
// ----------------------------------------------------------------------------
// Accepts one payload byte per cycle; the parser updates its state in the
// same cycle and queues any message report and end-of-payload summary in a
// 4-entry FIFO, from which the output stage emits one transaction per cycle
// into a registered output while out_ready allows. A byte that yields both
// a report and a summary is emitted as two transactions, report first, so
// input stalls only on a full FIFO behind a stalled or busy output. cfg_data
// sets the per-payload message limit (reset 100, 0 = unlimited), always ready.
module payload_message_deframer #(
  parameter int HEADER_BYTES       = 8,
  parameter int TYPE_TABLE_ENTRIES = 22
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  pmd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output pmd_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);

  logic           accept;
  logic           push;
  logic           pop;
  logic           q_not_empty;
  logic           q_full;
  pmd_pkg::work_t push_entry;
  pmd_pkg::work_t head;

  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  pmd_front #(
    .HEADER_BYTES(HEADER_BYTES)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .item      (in_data),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_limit (cfg_data),
    .push      (push),
    .push_entry(push_entry)
  );

  pmd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_entry(push_entry),
    .pop       (pop),
    .head      (head),
    .not_empty (q_not_empty),
    .full      (q_full)
  );

  pmd_back #(
    .TYPE_TABLE_ENTRIES(TYPE_TABLE_ENTRIES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_valid(q_not_empty),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
